// ===== hdl/mstp_pkg.sv =====
// ----------------------------------------------------------------------------
// mstp_pkg
// Shared types and constants for the maximum spanning tree core.
// ----------------------------------------------------------------------------
package mstp_pkg;

  localparam int MAX_NODES_DEF = 32;
  localparam int NODE_COUNT_W  = 6;
  localparam int ID_W          = 5;
  localparam int WEIGHT_W      = 32;

  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 6'd32;

  // One weight load request.
  typedef struct packed {
    logic [ID_W-1:0]            row_index;
    logic [ID_W-1:0]            col_index;
    logic signed [WEIGHT_W-1:0] pair_weight;
    logic                       load_done;
  } in_req_t;

  // One parent report.
  typedef struct packed {
    logic [ID_W-1:0] node_id;
    logic [ID_W-1:0] parent_id;
    logic            has_parent;
    logic            final_node;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_ADD,
    ST_EMIT
  } mst_state_t;

endpackage

// ===== hdl/max_spanning_tree_prim_core.sv =====
// ----------------------------------------------------------------------------
// max_spanning_tree_prim_core
// Dense weight matrix store plus a Prim sequencer that builds a maximum
// spanning tree rooted at node 0 and reports each node's parent in order.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  in_*     | in  | in_valid/in_stall  | in_req_t  (row, col, weight, done)
//  out_*    | out | out_valid/out_stall| out_rsp_t (node, parent, flags)
//  cfg_*    | in  | cfg_valid/cfg_ready| node_count (6 bits)
//
//  A request without load_done is stored in the weight memory; loads run back
//  to back. A request with load_done builds the tree in n-1 scans over nodes
//  1..n-1: each node outside the tree takes a memory read, then the shared
//  compare unit; a tree node takes only the read; each scan closes with an
//  end-of-scan and an add step. The n nodes are then reported in order.
//  in_stall is high for the whole build and report phase. Reset is
//  synchronous, active low; the weight memory has no reset and no clear.
//  out_stall only holds the output register; the report sequencer waits.
// ----------------------------------------------------------------------------
module max_spanning_tree_prim_core
  import mstp_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_req_t                 in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_rsp_t                out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [NODE_COUNT_W-1:0] cfg_data
);

  localparam int NW = $clog2(MAX_NODES);           // node index width
  localparam int CW = $clog2(MAX_NODES + 1);       // count width
  localparam int AW = $clog2(MAX_NODES * MAX_NODES);
  localparam int DEPTH = MAX_NODES * MAX_NODES;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  mst_state_t state_r, state_nxt;

  logic [NODE_COUNT_W-1:0] node_count_r;

  logic [CW-1:0]        n_r, n_nxt;          // nodes in this build
  logic [CW-1:0]        left_r, left_nxt;    // nodes still to add
  logic [CW-1:0]        it_r, it_nxt;        // scan position
  logic [CW-1:0]        o_r, o_nxt;          // report position
  logic [NW-1:0]        cur_r, cur_nxt;      // node just added
  logic [NW-1:0]        pick_r, pick_nxt;    // best candidate so far
  logic signed [WEIGHT_W-1:0] pick_w_r, pick_w_nxt;
  logic                 first_r, first_nxt;  // no candidate seen yet
  logic                 init_r, init_nxt;    // root scan: copy unconditionally
  logic [MAX_NODES-1:0] mask_r, mask_nxt;    // in-tree flags

  logic                 out_valid_r, out_valid_nxt;
  out_rsp_t             out_data_r, out_data_nxt;

  // Weight memory, one read port registered.
  logic signed [WEIGHT_W-1:0] wmem [DEPTH];
  logic signed [WEIGHT_W-1:0] rdata_r;

  // Per node working values.
  logic signed [WEIGHT_W-1:0] bw_r [MAX_NODES];
  logic [NW-1:0]              bp_r [MAX_NODES];

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic in_acc, out_load, mem_wr, mem_rd, bw_we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [NW-1:0] it_idx;
  logic [CW-1:0] n_build;
  logic [NODE_COUNT_W:0] nc_ext;
  logic signed [WEIGHT_W-1:0] new_bw;
  logic upd;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign it_idx = it_r[NW-1:0];

  // Clamp node_count into 1..MAX_NODES.
  assign nc_ext = {1'b0, node_count_r};
  always_comb begin
    if (node_count_r == '0) begin
      n_build = CW'(1);
    end else if (nc_ext > (NODE_COUNT_W+1)'(MAX_NODES)) begin
      n_build = CW'(MAX_NODES);
    end else begin
      n_build = CW'(node_count_r);
    end
  end

  // Out-of-range indices drop the write.
  assign mem_wr = in_acc && (32'(in_data.row_index) < 32'(MAX_NODES))
                         && (32'(in_data.col_index) < 32'(MAX_NODES));
  assign wr_addr = AW'(NW'(in_data.row_index)) * AW'(MAX_NODES)
                 + AW'(NW'(in_data.col_index));
  assign rd_addr = AW'(cur_r) * AW'(MAX_NODES) + AW'(it_idx);
  assign mem_rd  = (state_r == ST_READ);

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      wmem[wr_addr] <= in_data.pair_weight;
    end
    if (mem_rd) begin
      rdata_r <= wmem[rd_addr];
    end
  end

  // Shared compare unit: relax, then candidate select.
  assign upd    = init_r || (bw_r[it_idx] < rdata_r);
  assign new_bw = upd ? rdata_r : bw_r[it_idx];
  assign bw_we  = (state_r == ST_UPDATE);

  always_ff @(posedge clk) begin
    if (bw_we) begin
      bw_r[it_idx] <= new_bw;
      if (upd) begin
        bp_r[it_idx] <= cur_r;
      end
    end
  end

  // Output slot is free or drains this cycle.
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.load_done) begin
          state_nxt = (n_build < CW'(2)) ? ST_EMIT : ST_READ;
        end
      end
      ST_READ: begin
        if (it_r == n_r) begin
          state_nxt = ST_ADD;
        end else if (!mask_r[it_idx]) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_READ;
      ST_ADD: begin
        state_nxt = (left_r == CW'(1)) ? ST_EMIT : ST_READ;
      end
      ST_EMIT: begin
        if (out_load && (o_r == n_r - CW'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    n_nxt         = n_r;
    left_nxt      = left_r;
    it_nxt        = it_r;
    o_nxt         = o_r;
    cur_nxt       = cur_r;
    pick_nxt      = pick_r;
    pick_w_nxt    = pick_w_r;
    first_nxt     = first_r;
    init_nxt      = init_r;
    mask_nxt      = mask_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.load_done) begin
          n_nxt     = n_build;
          left_nxt  = n_build - CW'(1);
          mask_nxt  = MAX_NODES'(1);
          cur_nxt   = '0;
          it_nxt    = CW'(1);
          first_nxt = 1'b1;
          init_nxt  = 1'b1;
          o_nxt     = '0;
        end
      end
      ST_READ: begin
        if (it_r != n_r && mask_r[it_idx]) begin
          it_nxt = it_r + CW'(1);
        end
      end
      ST_UPDATE: begin
        // strict greater-than: ties stay with the lower index
        if (first_r || (new_bw > pick_w_r)) begin
          pick_nxt   = it_idx;
          pick_w_nxt = new_bw;
        end
        first_nxt = 1'b0;
        it_nxt    = it_r + CW'(1);
      end
      ST_ADD: begin
        cur_nxt          = pick_r;
        mask_nxt[pick_r] = 1'b1;
        left_nxt         = left_r - CW'(1);
        it_nxt           = CW'(1);
        first_nxt        = 1'b1;
        init_nxt         = 1'b0;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.node_id    = ID_W'(o_r);
          out_data_nxt.parent_id  = (o_r == '0) ? '0 : ID_W'(bp_r[o_r[NW-1:0]]);
          out_data_nxt.has_parent = (o_r != '0);
          out_data_nxt.final_node = (o_r == n_r - CW'(1));
          o_nxt                   = o_r + CW'(1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= NODE_COUNT_RST;
      mask_r       <= '0;
      out_valid_r  <= 1'b0;
      n_r          <= '0;
      left_r       <= '0;
      it_r         <= '0;
      o_r          <= '0;
      cur_r        <= '0;
      pick_r       <= '0;
      first_r      <= 1'b0;
      init_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      left_r      <= left_nxt;
      it_r        <= it_nxt;
      o_r         <= o_nxt;
      cur_r       <= cur_nxt;
      pick_r      <= pick_nxt;
      first_r     <= first_nxt;
      init_r      <= init_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pick_w_r   <= pick_w_nxt;
    out_data_r <= out_data_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_root_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.has_parent == (out_data_r.node_id != '0)))
    else $error("root flag mismatch");

  a_root_in_tree: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_UPDATE || state_r == ST_ADD) |-> mask_r[0])
    else $error("root missing from tree");

  a_pick_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD) |-> !mask_r[pick_r])
    else $error("picked node already in tree");

  a_add_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD) |=> ($countones(mask_r) == $past($countones(mask_r)) + 1))
    else $error("tree did not grow by one node");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_UPDATE) |-> (it_r <= n_r && it_r != '0))
    else $error("scan index out of range");

endmodule
